// ===== hdl/fbpa_pkg.sv =====
// ---------------------------------------------------------------------------
// fbpa_pkg
// Shared widths, codes and controller/datapath interface types for the
// fixed block pool allocator.
// ---------------------------------------------------------------------------
package fbpa_pkg;

	localparam int MAX_BLOCKS  = 64;
	localparam int IDX_W       = $clog2(MAX_BLOCKS);
	localparam int DIVB_W      = $clog2(IDX_W);
	localparam int CNT_W       = IDX_W + 1;
	localparam int ADDR_W      = 32;
	localparam int LEN_W       = 27;
	localparam int TOTAL_W     = CNT_W + LEN_W;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 80;

	// Pool limits
	localparam logic [TOTAL_W-1:0] POOL_LIMIT = TOTAL_W'(64 * 1024 * 1024);
	localparam logic [LEN_W-1:0]   PAGE_SIZE  = LEN_W'(1 << 12);
	localparam logic [LEN_W-1:0]   PAGE_MASK  = LEN_W'((1 << 12) - 1);

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_LENGTH = 2'd2;

	// Request opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_EMPTY      = 3'd1,
		ST_NO_BLOCK   = 3'd2,
		ST_NOT_LOCKED = 3'd3,
		ST_BAD_CONFIG = 3'd4
	} status_t;

	// Controller to datapath
	typedef struct packed {
		logic              accept;   // capture request
		logic              check;    // config check, first-free search, offset
		logic              alloc;    // block address of the first free block
		logic              div;      // one restoring division step
		logic [DIVB_W-1:0] div_bit;  // quotient bit worked on by this step
		logic              update;   // decide status, update lock bits
		logic              cnt1;     // group popcounts
		logic              cnt2;     // final free count
		logic              load;     // move result into output register
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic op;        // opcode of the request in flight
		logic out_room;  // output register can take a result
	} sts_t;

endpackage

// ===== hdl/fbpa_ctrl.sv =====
// ---------------------------------------------------------------------------
// fbpa_ctrl
// Request sequencer: walks one request through check, address or
// division steps, lock update, free count and output hand-off.
// ---------------------------------------------------------------------------
module fbpa_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  fbpa_pkg::sts_t  sts,
	output fbpa_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_ALOC,
		S_DIV,
		S_UPD,
		S_CNT1,
		S_CNT2,
		S_DONE
	} state_t;

	state_t                        state_q;
	logic [fbpa_pkg::DIVB_W-1:0]   div_bit_q;

	// State register and division step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_bit_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (req_valid) state_q <= S_CHECK;
				end
				S_CHECK: begin
					div_bit_q <= fbpa_pkg::DIVB_W'(fbpa_pkg::IDX_W - 1);
					state_q   <= (sts.op == fbpa_pkg::OP_FREE) ? S_DIV : S_ALOC;
				end
				S_ALOC: state_q <= S_UPD;
				S_DIV: begin
					if (div_bit_q == '0) state_q <= S_UPD;
					else div_bit_q <= div_bit_q - fbpa_pkg::DIVB_W'(1);
				end
				S_UPD:  state_q <= S_CNT1;
				S_CNT1: state_q <= S_CNT2;
				S_CNT2: state_q <= S_DONE;
				S_DONE: begin
					if (sts.out_room) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Command decode
	always_comb begin
		req_ready   = (state_q == S_IDLE);
		cmd         = '0;
		cmd.accept  = (state_q == S_IDLE) && req_valid;
		cmd.check   = (state_q == S_CHECK);
		cmd.alloc   = (state_q == S_ALOC);
		cmd.div     = (state_q == S_DIV);
		cmd.div_bit = div_bit_q;
		cmd.update  = (state_q == S_UPD);
		cmd.cnt1    = (state_q == S_CNT1);
		cmd.cnt2    = (state_q == S_CNT2);
		cmd.load    = (state_q == S_DONE) && sts.out_room;
	end

endmodule

// ===== hdl/fbpa_datapath.sv =====
// ---------------------------------------------------------------------------
// fbpa_datapath
// Configuration registers, lock bits, first-free search, address
// arithmetic, address-to-index division, free count and output register.
// ---------------------------------------------------------------------------
module fbpa_datapath (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  fbpa_pkg::cmd_t                         cmd,
	output fbpa_pkg::sts_t                         sts,
	// configuration writes
	input  logic                                   cfg_wr_en,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]         cfg_addr,
	input  logic [fbpa_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	// request payload
	input  logic                                   in_opcode,
	input  logic [fbpa_pkg::ADDR_W-1:0]            in_free_address,
	// result
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output fbpa_pkg::status_t                      out_status,
	output logic [fbpa_pkg::ADDR_W-1:0]            out_block_address,
	output logic [fbpa_pkg::IDX_W-1:0]             out_block_index,
	output logic [fbpa_pkg::LEN_W-1:0]             out_granted_length,
	output logic [fbpa_pkg::CNT_W-1:0]             out_free_blocks
);

	localparam int NB   = fbpa_pkg::MAX_BLOCKS;
	localparam int NGRP = NB / 8;
	localparam int QW   = fbpa_pkg::ADDR_W + 1;

	// configuration
	logic [fbpa_pkg::ADDR_W-1:0] base_q;
	logic [fbpa_pkg::CNT_W-1:0]  count_q;
	logic [fbpa_pkg::LEN_W-1:0]  length_q;

	// state and request
	logic [NB-1:0]               lock_q;
	logic                        op_q;
	logic [fbpa_pkg::ADDR_W-1:0] want_q;

	// working registers
	logic                        cfg_ok_q;
	logic                        ff_found_q;
	logic [fbpa_pkg::IDX_W-1:0]  ff_idx_q;
	logic                        in_range_q;
	logic [fbpa_pkg::ADDR_W-1:0] rem_q;
	logic [fbpa_pkg::IDX_W-1:0]  quo_q;
	logic [fbpa_pkg::ADDR_W-1:0] blk_addr_q;
	fbpa_pkg::status_t           res_status_q;
	logic [fbpa_pkg::ADDR_W-1:0] res_addr_q;
	logic [fbpa_pkg::IDX_W-1:0]  res_idx_q;
	logic [fbpa_pkg::LEN_W-1:0]  res_len_q;
	logic [3:0]                  grp_q [NGRP];
	logic [fbpa_pkg::CNT_W-1:0]  res_free_q;

	// output register
	logic                        out_valid_q;
	fbpa_pkg::status_t           out_status_q;
	logic [fbpa_pkg::ADDR_W-1:0] out_addr_q;
	logic [fbpa_pkg::IDX_W-1:0]  out_idx_q;
	logic [fbpa_pkg::LEN_W-1:0]  out_len_q;
	logic [fbpa_pkg::CNT_W-1:0]  out_free_q;

	// combinational helpers
	logic [NB-1:0]                in_use_mask;
	logic [NB-1:0]                free_vec;
	logic [fbpa_pkg::TOTAL_W-1:0] total;
	logic                         cfg_ok;
	logic                         ff_found;
	logic [fbpa_pkg::IDX_W-1:0]   ff_idx;
	logic [fbpa_pkg::ADDR_W-1:0]  offset;
	logic [QW-1:0]                divisor;
	logic [QW-1:0]                trial;
	logic                         free_found;
	logic [fbpa_pkg::CNT_W-1:0]   grp_sum;

	// Blocks below block_count that are unlocked
	always_comb begin
		for (int i = 0; i < NB; i++) begin
			in_use_mask[i] = (fbpa_pkg::CNT_W'(i) < count_q);
		end
		free_vec = ~lock_q & in_use_mask;
	end

	// Lowest-indexed free block
	always_comb begin
		ff_found = 1'b0;
		ff_idx   = '0;
		for (int i = NB - 1; i >= 0; i--) begin
			if (free_vec[i]) begin
				ff_found = 1'b1;
				ff_idx   = fbpa_pkg::IDX_W'(i);
			end
		end
	end

	// Pool geometry check
	always_comb begin
		total  = fbpa_pkg::TOTAL_W'(count_q) * fbpa_pkg::TOTAL_W'(length_q);
		cfg_ok = (count_q >= fbpa_pkg::CNT_W'(2))
			&& (count_q <= fbpa_pkg::CNT_W'(NB))
			&& (length_q != '0)
			&& !(((length_q & fbpa_pkg::PAGE_MASK) != '0)
				&& (length_q >= fbpa_pkg::PAGE_SIZE))
			&& (total <= fbpa_pkg::POOL_LIMIT);
		offset = want_q - base_q;
	end

	// Restoring division step: remainder against length shifted by div_bit
	always_comb begin
		divisor = QW'(length_q) << cmd.div_bit;
		trial   = {1'b0, rem_q} - divisor;
	end

	assign free_found = in_range_q && (rem_q == '0);

	// Sum of group popcounts
	always_comb begin
		grp_sum = '0;
		for (int g = 0; g < NGRP; g++) begin
			grp_sum = grp_sum + fbpa_pkg::CNT_W'(grp_q[g]);
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q   <= '0;
			count_q  <= '0;
			length_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_addr)
				fbpa_pkg::REG_POOL_BASE:    base_q   <= cfg_wdata[fbpa_pkg::ADDR_W-1:0];
				fbpa_pkg::REG_BLOCK_COUNT:  count_q  <= cfg_wdata[fbpa_pkg::CNT_W-1:0];
				fbpa_pkg::REG_BLOCK_LENGTH: length_q <= cfg_wdata[fbpa_pkg::LEN_W-1:0];
				default: ;
			endcase
		end
	end

	// Lock bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q <= '0;
		end else if (cmd.update && cfg_ok_q) begin
			if (op_q == fbpa_pkg::OP_ALLOC) begin
				if (ff_found_q) lock_q[ff_idx_q] <= 1'b1;
			end else if (free_found) begin
				lock_q[quo_q] <= 1'b0;
			end
		end
	end

	// Request capture, search, arithmetic and result assembly
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= in_opcode;
			want_q <= in_free_address;
		end
		if (cmd.check) begin
			cfg_ok_q   <= cfg_ok;
			ff_found_q <= ff_found;
			ff_idx_q   <= ff_idx;
			in_range_q <= ({{(fbpa_pkg::TOTAL_W-fbpa_pkg::ADDR_W){1'b0}}, offset} < total);
			rem_q      <= offset;
			quo_q      <= '0;
		end
		if (cmd.alloc) begin
			blk_addr_q <= base_q + fbpa_pkg::ADDR_W'(ff_idx_q * length_q);
		end
		if (cmd.div) begin
			if (!trial[QW-1]) begin
				rem_q <= trial[fbpa_pkg::ADDR_W-1:0];
				quo_q[cmd.div_bit] <= 1'b1;
			end
		end
		if (cmd.update) begin
			if (!cfg_ok_q) begin
				res_status_q <= fbpa_pkg::ST_BAD_CONFIG;
				res_addr_q   <= '0;
				res_idx_q    <= '0;
				res_len_q    <= '0;
			end else if (op_q == fbpa_pkg::OP_ALLOC) begin
				if (ff_found_q) begin
					res_status_q <= fbpa_pkg::ST_OK;
					res_addr_q   <= blk_addr_q;
					res_idx_q    <= ff_idx_q;
					res_len_q    <= length_q;
				end else begin
					res_status_q <= fbpa_pkg::ST_EMPTY;
					res_addr_q   <= '0;
					res_idx_q    <= '0;
					res_len_q    <= '0;
				end
			end else if (free_found) begin
				if (lock_q[quo_q]) begin
					res_status_q <= fbpa_pkg::ST_OK;
				end else begin
					res_status_q <= fbpa_pkg::ST_NOT_LOCKED;
				end
				res_addr_q <= want_q;
				res_idx_q  <= quo_q;
				res_len_q  <= '0;
			end else begin
				res_status_q <= fbpa_pkg::ST_NO_BLOCK;
				res_addr_q   <= '0;
				res_idx_q    <= '0;
				res_len_q    <= '0;
			end
		end
		// popcount in two registered levels, after the lock update
		if (cmd.cnt1) begin
			for (int g = 0; g < NGRP; g++) begin
				grp_q[g] <= 4'($countones(free_vec[g*8 +: 8]));
			end
		end
		if (cmd.cnt2) begin
			res_free_q <= (res_status_q == fbpa_pkg::ST_BAD_CONFIG) ? '0 : grp_sum;
		end
		if (cmd.load) begin
			out_status_q <= res_status_q;
			out_addr_q   <= res_addr_q;
			out_idx_q    <= res_idx_q;
			out_len_q    <= res_len_q;
			out_free_q   <= res_free_q;
		end
	end

	// Output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.op             = op_q;
	assign sts.out_room       = !out_valid_q || out_ready;
	assign out_valid          = out_valid_q;
	assign out_status         = out_status_q;
	assign out_block_address  = out_addr_q;
	assign out_block_index    = out_idx_q;
	assign out_granted_length = out_len_q;
	assign out_free_blocks    = out_free_q;

`ifndef SYNTHESIS
	// a successful allocate leaves its block locked
	a_alloc_locks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && cfg_ok_q && (op_q == fbpa_pkg::OP_ALLOC) && ff_found_q
		|=> lock_q[res_idx_q])
		else $error("allocated block not locked");

	// a successful free leaves its block unlocked
	a_free_unlocks: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.update && cfg_ok_q && (op_q == fbpa_pkg::OP_FREE) && free_found
		|=> !lock_q[res_idx_q])
		else $error("freed block still locked");

	// only a successful allocate grants a length
	a_len_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_len_q != '0) |-> (out_status_q == fbpa_pkg::ST_OK))
		else $error("length granted on failed request");

	// bad configuration result carries nothing else
	a_bad_cfg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_status_q == fbpa_pkg::ST_BAD_CONFIG)
		|-> (out_free_q == '0) && (out_addr_q == '0) && (out_idx_q == '0))
		else $error("bad configuration result not cleared");
`endif

endmodule

// ===== hdl/fixed_block_pool_allocator_core.sv =====
// ---------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// First-fit allocator over a pool of equal-sized blocks with one lock bit
// per block.
// ---------------------------------------------------------------------------
// Usage:
//   Requests arrive on the s_axis stream (opcode 0 allocate, 1 free by
//   start address); one result per request leaves on m_axis.
//   Pool geometry is written through cfg_wr_en/cfg_addr/cfg_wdata while
//   the block is idle: 0 pool base, 1 block count, 2 block length.
//   A free resolves its block index with a six-step restoring division of
//   (address - base) by the block length. One request is worked on at a
//   time; the next is accepted only after the result has entered the
//   output register.
//   The output register holds a result until m_axis_tready; a new request
//   may be accepted and processed meanwhile, and the sequencer waits at its
//   last step while the previous result is still unread.
//   Reset clears the configuration registers and every lock bit (all
//   blocks free) and leaves both streams empty.
// ---------------------------------------------------------------------------
module fixed_block_pool_allocator_core (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// configuration
	input  logic                                 cfg_wr_en,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]       cfg_addr,
	input  logic [fbpa_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	// requests
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	// [0] opcode, [32:1] free_address, [39:33] zero
	input  logic [fbpa_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
	// results
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	// [2:0] status, [34:3] block_address, [40:35] block_index,
	// [67:41] granted_length, [74:68] free_blocks, [79:75] zero
	output logic [fbpa_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);

	localparam int OUT_USED = 3 + fbpa_pkg::ADDR_W + fbpa_pkg::IDX_W
		+ fbpa_pkg::LEN_W + fbpa_pkg::CNT_W;

	fbpa_pkg::cmd_t                cmd;
	fbpa_pkg::sts_t                sts;
	fbpa_pkg::status_t             res_status;
	logic [fbpa_pkg::ADDR_W-1:0]   res_addr;
	logic [fbpa_pkg::IDX_W-1:0]    res_idx;
	logic [fbpa_pkg::LEN_W-1:0]    res_len;
	logic [fbpa_pkg::CNT_W-1:0]    res_free;

	fbpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (s_axis_tvalid),
		.req_ready (s_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fbpa_datapath u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_addr           (cfg_addr),
		.cfg_wdata          (cfg_wdata),
		.in_opcode          (s_axis_tdata[0]),
		.in_free_address    (s_axis_tdata[fbpa_pkg::ADDR_W:1]),
		.out_valid          (m_axis_tvalid),
		.out_ready          (m_axis_tready),
		.out_status         (res_status),
		.out_block_address  (res_addr),
		.out_block_index    (res_idx),
		.out_granted_length (res_len),
		.out_free_blocks    (res_free)
	);

	// Pack result fields, lowest field first
	assign m_axis_tdata = {{(fbpa_pkg::OUT_TDATA_W-OUT_USED){1'b0}},
		res_free, res_len, res_idx, res_addr, res_status};

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench
// Drives allocate and free requests into the fixed block pool allocator
// under several pool geometries and random back-pressure, predicts every
// reply from its own copy of the lock table and compares each reply field
// by field.
// ---------------------------------------------------------------------------
module testbench;
	import fbpa_pkg::*;

	// Reply layout, status in the lowest bits
	typedef struct packed {
		logic [CNT_W-1:0]  free_blocks;
		logic [LEN_W-1:0]  granted_length;
		logic [IDX_W-1:0]  block_index;
		logic [ADDR_W-1:0] block_address;
		status_t           status;
	} pool_reply_t;

	localparam int REPLY_W = $bits(pool_reply_t);

	// Lock table shadow: predicts replies and checks them in order
	class pool_tracker;
		logic [ADDR_W-1:0] base;
		logic [CNT_W-1:0]  count;
		logic [LEN_W-1:0]  len;
		bit                locked [MAX_BLOCKS];
		pool_reply_t       awaited_replies [$];
		int                errors;

		function new();
			base   = '0;
			count  = '0;
			len    = '0;
			errors = 0;
			foreach (locked[i])
				locked[i] = 1'b0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
			case (idx)
				REG_POOL_BASE:    base  = value[ADDR_W-1:0];
				REG_BLOCK_COUNT:  count = value[CNT_W-1:0];
				REG_BLOCK_LENGTH: len   = value[LEN_W-1:0];
				default: ;
			endcase
		endfunction

		function int unsigned pending();
			return awaited_replies.size();
		endfunction

		// Blocks that can be addressed under the current count
		function int unsigned span();
			return (count > MAX_BLOCKS) ? MAX_BLOCKS : count;
		endfunction

		function bit geometry_ok();
			logic [63:0] total;
			total = 64'(count) * 64'(len);
			if (count < 2 || count > MAX_BLOCKS)
				return 1'b0;
			if (len == 0)
				return 1'b0;
			if ((len & PAGE_MASK) != 0 && len >= PAGE_SIZE)
				return 1'b0;
			if (total > 64'(POOL_LIMIT))
				return 1'b0;
			return 1'b1;
		endfunction

		// Start address, wrapped to the address width
		function logic [ADDR_W-1:0] block_addr(int unsigned i);
			return base + ADDR_W'(i) * ADDR_W'(len);
		endfunction

		function logic [CNT_W-1:0] free_count();
			logic [CNT_W-1:0] n;
			n = '0;
			for (int i = 0; i < span(); i++)
				if (!locked[i])
					n = n + 1'b1;
			return n;
		endfunction

		// Random locked block within the pool, or -1 if none
		function int pick_locked();
			int hits [$];
			for (int i = 0; i < span(); i++)
				if (locked[i])
					hits.push_back(i);
			if (hits.size() == 0)
				return -1;
			return hits[$urandom_range(hits.size() - 1)];
		endfunction

		// Work out the reply to an accepted request and queue it
		function void note_request(logic op, logic [ADDR_W-1:0] addr);
			pool_reply_t r;
			int          hit;
			r   = '0;
			hit = -1;
			if (!geometry_ok()) begin
				r.status = ST_BAD_CONFIG;
			end else if (op == OP_ALLOC) begin
				for (int i = 0; i < count && hit < 0; i++)
					if (!locked[i])
						hit = i;
				if (hit < 0) begin
					r.status = ST_EMPTY;
				end else begin
					locked[hit]      = 1'b1;
					r.status         = ST_OK;
					r.block_address  = block_addr(hit);
					r.block_index    = IDX_W'(hit);
					r.granted_length = len;
					r.free_blocks    = free_count();
				end
			end else begin
				// lowest index wins on a shared address
				for (int i = 0; i < count && hit < 0; i++)
					if (block_addr(i) == addr)
						hit = i;
				if (hit < 0) begin
					r.status = ST_NO_BLOCK;
				end else begin
					r.status        = locked[hit] ? ST_OK : ST_NOT_LOCKED;
					locked[hit]     = 1'b0;
					r.block_address = block_addr(hit);
					r.block_index   = IDX_W'(hit);
				end
				r.free_blocks = free_count();
			end
			awaited_replies.push_back(r);
		endfunction

		function void compare(string field, longint unsigned want, longint unsigned got);
			if (want != got) begin
				$error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
				errors++;
			end
		endfunction

		function void check_reply(logic [OUT_TDATA_W-1:0] data);
			pool_reply_t got;
			pool_reply_t want;
			got = data[REPLY_W-1:0];
			if (awaited_replies.size() == 0) begin
				$error("reply with none outstanding: 0x%0h", data);
				errors++;
				return;
			end
			want = awaited_replies.pop_front();
			compare("status", want.status, got.status);
			compare("block_address", want.block_address, got.block_address);
			compare("block_index", want.block_index, got.block_index);
			compare("granted_length", want.granted_length, got.granted_length);
			compare("free_blocks", want.free_blocks, got.free_blocks);
			compare("padding", 0, data[OUT_TDATA_W-1:REPLY_W]);
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_wr_en;
	logic [CFG_IDX_W-1:0]   cfg_addr;
	logic [CFG_DATA_W-1:0]  cfg_wdata;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// [0] opcode, [32:1] free_address, [39:33] zero
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// [2:0] status, [34:3] block_address, [40:35] block_index,
	// [67:41] granted_length, [74:68] free_blocks, [79:75] zero
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	pool_tracker pool = new();
	int unsigned snd_idle_pct;
	int unsigned rcv_idle_pct;

	fixed_block_pool_allocator_core uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_addr      (cfg_addr),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		#5_000_000;
		$display("CHECK FAILED");
		$finish;
	end

	// Reply side: random stalls, every accepted transaction checked
	initial begin
		m_axis_tready <= 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready)
				pool.check_reply(m_axis_tdata);
		end
	end

	task automatic set_idling(int unsigned mode);
		case (mode)
			0: begin
				snd_idle_pct = 33;
				rcv_idle_pct = 86;
			end
			1: begin
				snd_idle_pct = 86;
				rcv_idle_pct = 33;
			end
			default: begin
				snd_idle_pct = 0;
				rcv_idle_pct = 0;
			end
		endcase
	endtask

	// One request transaction, with a random gap in front
	task automatic send(logic op, logic [ADDR_W-1:0] addr);
		while ($urandom_range(99) < snd_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {7'd0, addr, op};
		do
			@(posedge clk);
		while (!s_axis_tready);
		pool.note_request(op, addr);
	endtask

	// Hold requests until every reply is in, then let the pipeline settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (pool.pending() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		pool.set_reg(idx, value);
	endtask

	// Noisy writes put random bits above the register width
	task automatic configure(logic [31:0] base, logic [31:0] count, logic [31:0] len,
			bit noisy);
		logic [31:0] hi;
		hi = $urandom;
		write_reg(REG_POOL_BASE, base);
		write_reg(REG_BLOCK_COUNT, noisy ? {hi[31:CNT_W], count[CNT_W-1:0]} : count);
		write_reg(REG_BLOCK_LENGTH, noisy ? {hi[31:LEN_W], len[LEN_W-1:0]} : len);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
	endtask

	// Geometry for a random phase
	task automatic random_geometry();
		logic [31:0] count;
		logic [31:0] len;
		int unsigned kind;
		count = ($urandom_range(7) == 0) ? $urandom_range(127) : $urandom_range(2, 64);
		kind  = $urandom_range(9);
		if (kind < 4)
			len = $urandom_range(1, 4095);
		else if (kind < 8)
			len = 4096 * $urandom_range(1, 16384 / ((count < 2) ? 2 : count));
		else
			len = $urandom & 32'h07FF_FFFF;
		configure($urandom, count, len, $urandom_range(1));
	endtask

	// Runs of mostly frees (most of blocks in use) alternate with runs of mostly allocates
	task automatic random_requests(int unsigned n);
		int unsigned       r;
		int unsigned       alloc_pct;
		int unsigned       width;
		int                idx;
		logic [ADDR_W-1:0] a;
		for (int unsigned k = 0; k < n; k++) begin
			alloc_pct = ((k / 60) % 2) ? 80 : 25;
			width     = pool.span();
			a         = $urandom;
			if ($urandom_range(99) < alloc_pct) begin
				send(OP_ALLOC, a);
			end else begin
				r   = $urandom_range(99);
				idx = pool.pick_locked();
				if (r < 60 && idx >= 0) begin
					a = pool.block_addr(idx);
				end else if (r < 80 && width > 0) begin
					a = pool.block_addr($urandom_range(width - 1));
				end else if (r < 90 && width > 0) begin
					// one byte off a block start
					a = pool.block_addr($urandom_range(width - 1));
					if ($urandom_range(1))
						a = a + 1'b1;
					else
						a = a - 1'b1;
				end
				send(OP_FREE, a);
			end
		end
	endtask

	initial begin
		arst_n        <= 1'b0;
		cfg_wr_en     <= 1'b0;
		cfg_addr      <= '0;
		cfg_wdata     <= '0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		set_idling(0);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Registers at reset make an invalid pool
		send(OP_ALLOC, 32'h0000_0000);
		send(OP_FREE, 32'h0000_0000);
		drain();

		// Four pages that wrap past the top of the address space
		configure(32'hFFFF_E000, 4, 4096, 1'b0);
		repeat (4) send(OP_ALLOC, 32'hFFFF_FFFF);
		send(OP_ALLOC, 32'h0000_0000);  // pool empty
		send(OP_FREE, 32'h0000_0000);
		send(OP_FREE, 32'h0000_0000);   // already free
		send(OP_FREE, 32'hFFFF_FFFF);   // no block there
		send(OP_FREE, 32'h0000_0001);   // inside a block, not its start
		send(OP_FREE, 32'h0000_1000);
		send(OP_ALLOC, 32'h5555_5555);
		send(OP_FREE, 32'hFFFF_E000);
		drain();

		// Invalid geometries: count too low and too high, zero length,
		// unaligned large length, pool over the size limit
		configure(32'h0000_0000, 1, 16, 1'b0);
		send(OP_ALLOC, 32'h0);
		send(OP_FREE, 32'h0);
		drain();
		configure(32'h0000_0000, 65, 16, 1'b0);
		send(OP_ALLOC, 32'h0);
		send(OP_FREE, 32'h0);
		drain();
		configure(32'h0000_0000, 8, 0, 1'b0);
		send(OP_ALLOC, 32'h0);
		send(OP_FREE, 32'h0);
		drain();
		configure(32'h0000_0000, 8, 4097, 1'b0);
		send(OP_ALLOC, 32'h0);
		send(OP_FREE, 32'h0);
		drain();
		configure(32'h0000_0000, 2, 32'h0400_0000, 1'b0);
		send(OP_ALLOC, 32'h0);
		send(OP_FREE, 32'h0);
		drain();

		// Random phases; lock bits carry over between geometries
		for (int unsigned ph = 0; ph < 9; ph++) begin
			set_idling(ph / 3);
			case (ph)
				0: configure($urandom, 64, 32'h0010_0000, 1'b0);
				1: configure(32'hFFFF_FFFF, 2, 1, 1'b0);
				2: configure(32'h0000_0000, 64, 4095, 1'b0);
				default: random_geometry();
			endcase
			random_requests(72);
			if (ph == 4)
				drain();
			random_requests(73);
			drain();
		end

		if (pool.errors == 0 && pool.pending() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ===== sim.f =====
hdl/fbpa_pkg.sv
hdl/fbpa_ctrl.sv
hdl/fbpa_datapath.sv
hdl/fixed_block_pool_allocator_core.sv
tb/sv/testbench.sv
